// File: rtl/core/pmst_pkg.sv
// shared types, constants and codes of the prefix max segment tree
`default_nettype none

package pmst_pkg;

    // tree geometry
    localparam int LEAF_BITS  = 10;
    localparam int LEAF_COUNT = 1 << LEAF_BITS;
    localparam int ADDR_BITS  = LEAF_BITS + 1;
    localparam int CNT_BITS   = LEAF_BITS + 1;
    localparam int VAL_BITS   = 48;
    localparam int STEP_BITS  = $clog2(LEAF_BITS + 2);

    typedef logic signed [VAL_BITS-1:0] val_t;
    typedef logic [ADDR_BITS-1:0]       addr_t;
    typedef logic [CNT_BITS-1:0]        cnt_t;
    typedef logic [LEAF_BITS-1:0]       pos_t;
    typedef logic [STEP_BITS-1:0]       step_t;
    typedef logic [1:0]                 func_t;

    localparam val_t VAL_NEG_ONE   = '1;
    localparam cnt_t CNT_LEAF_FULL = cnt_t'(LEAF_COUNT);

    // operation codes
    localparam func_t FUNC_WRITE       = 2'd0;
    localparam func_t FUNC_PREFIX_MAX  = 2'd1;
    localparam func_t FUNC_COUNT_BELOW = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF,
        ST_UP,
        ST_DESC_Q,
        ST_ROOT,
        ST_DESC_S,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t wr_addr;
        val_t  wr_data;
        addr_t rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic ge;
        val_t maxv;
    } cmp_res_t;

    typedef struct packed {
        logic valid;
        val_t max_value;
        cnt_t leading_count;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/core/pmst_node_ram.sv
// node memory of the tree: one write port, one registered read port
`default_nettype none

module pmst_node_ram
    import pmst_pkg::*;
(
    input  wire logic     clk,
    input  wire ram_req_t req,
    output val_t          rd_data
);

    logic [VAL_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/pmst_cmp_unit.sv
// shared signed compare and max unit
`default_nettype none

module pmst_cmp_unit
    import pmst_pkg::*;
(
    input  wire val_t a,
    input  wire val_t b,
    output cmp_res_t  res
);

    always_comb
    begin
        res.ge   = ($signed(a) >= $signed(b));
        res.maxv = res.ge ? a : b;
    end

endmodule

`default_nettype wire

// File: rtl/core/pmst_seq.sv
// sequencer and datapath registers that walk the tree one level a cycle
`default_nettype none

module pmst_seq
    import pmst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire func_t func,
    input  wire pos_t  position,
    input  wire val_t  operand_value,
    input  wire cnt_t  count_in_use,
    output ram_req_t   ram_req,
    input  wire val_t  rd_data,
    output val_t       cmp_a,
    output val_t       cmp_b,
    input  wire cmp_res_t cmp,
    output res_t       res,
    input  wire logic  res_take
);

    state_t state_reg, state_next;
    func_t  op_reg, op_next;
    addr_t  node_reg, node_next;
    step_t  step_reg, step_next;
    logic   pend_reg, pend_next;
    val_t   acc_reg, acc_next;
    val_t   thr_reg, thr_next;
    pos_t   last_reg, last_next;
    cnt_t   n_reg, n_next;
    cnt_t   cnt_reg, cnt_next;

    logic   accept;
    addr_t  parent;
    addr_t  node_left;
    addr_t  node_right;
    addr_t  node_step;
    cnt_t   idx_ext;
    cnt_t   pos_ext;
    cnt_t   n_minus_one;

    assign accept      = in_valid && (state_reg == ST_IDLE);
    assign in_stall    = (state_reg != ST_IDLE);
    assign parent      = node_reg >> 1;
    assign node_left   = {node_reg[ADDR_BITS-2:0], 1'b0};
    assign node_right  = {node_reg[ADDR_BITS-2:0], 1'b1};
    assign node_step   = cmp.ge ? node_left : node_right;
    assign idx_ext     = {1'b0, node_step[LEAF_BITS-1:0]};
    assign pos_ext     = {1'b0, position};
    assign n_minus_one = count_in_use - cnt_t'(1);

    // operand select for the shared compare unit
    always_comb
    begin
        if (state_reg inside {ST_UP, ST_DESC_Q})
        begin
            cmp_a = acc_reg;
            cmp_b = rd_data;
        end
        else if (state_reg inside {ST_ROOT, ST_DESC_S})
        begin
            cmp_a = rd_data;
            cmp_b = thr_reg;
        end
        else
        begin
            cmp_a = thr_reg;
            cmp_b = VAL_NEG_ONE;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (node_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_WRITE:       state_next = ST_LEAF;
                        FUNC_PREFIX_MAX:
                            state_next = (count_in_use == '0) ? ST_DONE : ST_DESC_Q;
                        FUNC_COUNT_BELOW:
                            state_next = (count_in_use == '0) ? ST_DONE : ST_ROOT;
                        default:          state_next = ST_DONE;
                    endcase
                end
            end
            ST_LEAF:   state_next = ST_UP;
            ST_UP:
            begin
                if (parent == addr_t'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DESC_Q:
            begin
                if (step_reg == step_t'(LEAF_BITS + 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ROOT:   state_next = cmp.ge ? ST_DESC_S : ST_DONE;
            ST_DESC_S:
            begin
                if (step_reg == step_t'(LEAF_BITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        op_next   = op_reg;
        node_next = node_reg;
        step_next = step_reg;
        pend_next = pend_reg;
        acc_next  = acc_reg;
        thr_next  = thr_reg;
        last_next = last_reg;
        n_next    = n_reg;
        cnt_next  = cnt_reg;
        ram_req.we      = 1'b0;
        ram_req.wr_addr = node_reg;
        ram_req.wr_data = cmp.maxv;
        ram_req.rd_addr = node_reg;

        res.valid         = (state_reg == ST_DONE);
        res.max_value     = (op_reg == FUNC_PREFIX_MAX) ? acc_reg : '0;
        res.leading_count = (op_reg == FUNC_COUNT_BELOW) ? cnt_reg : '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep every node to minus one after reset
                ram_req.we      = 1'b1;
                ram_req.wr_data = VAL_NEG_ONE;
                node_next       = node_reg + addr_t'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = func;
                    thr_next  = operand_value;
                    n_next    = count_in_use;
                    step_next = '0;
                    pend_next = 1'b0;
                    acc_next  = VAL_NEG_ONE;
                    cnt_next  = '0;
                    last_next = (pos_ext < count_in_use) ? position
                                                         : n_minus_one[LEAF_BITS-1:0];
                    if (func == FUNC_WRITE)
                    begin
                        node_next = {1'b1, position};
                    end
                    else
                    begin
                        node_next = addr_t'(1);
                    end
                    ram_req.rd_addr = addr_t'(1);
                end
            end
            ST_LEAF:
            begin
                // store the saturated leaf, fetch its sibling
                ram_req.we      = 1'b1;
                acc_next        = cmp.maxv;
                ram_req.rd_addr = node_reg ^ addr_t'(1);
            end
            ST_UP:
            begin
                ram_req.we      = 1'b1;
                ram_req.wr_addr = parent;
                acc_next        = cmp.maxv;
                node_next       = parent;
                ram_req.rd_addr = parent ^ addr_t'(1);
            end
            ST_DESC_Q:
            begin
                if (pend_reg)
                begin
                    acc_next = cmp.maxv;
                end
                step_next = step_reg + step_t'(1);
                if (step_reg < step_t'(LEAF_BITS))
                begin
                    // a set bit of the last index takes the whole left subtree
                    last_next = last_reg << 1;
                    if (last_reg[LEAF_BITS-1])
                    begin
                        ram_req.rd_addr = node_left;
                        pend_next       = 1'b1;
                        node_next       = node_right;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        node_next = node_left;
                    end
                end
                else
                begin
                    // leaf of the last index itself
                    ram_req.rd_addr = node_reg;
                    pend_next       = 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (!cmp.ge)
                begin
                    cnt_next = n_reg;
                end
                ram_req.rd_addr = node_left;
                step_next       = '0;
            end
            ST_DESC_S:
            begin
                node_next       = node_step;
                step_next       = step_reg + step_t'(1);
                ram_req.rd_addr = {node_step[ADDR_BITS-2:0], 1'b0};
                if (step_reg == step_t'(LEAF_BITS - 1))
                begin
                    cnt_next = (idx_ext < n_reg) ? idx_ext : n_reg;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            node_reg  <= '0;
            step_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        acc_reg  <= acc_next;
        thr_reg  <= thr_next;
        last_reg <= last_next;
        n_reg    <= n_next;
        cnt_reg  <= cnt_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/prefix_max_segment_tree_top.sv
// top level of the prefix max segment tree
`default_nettype none

// Max segment tree over 1024 signed 48-bit elements held in a 2047-node
// memory. Each input transfer carries one operation and yields one result
// transfer: func 0 writes one element (values below -1 are stored as -1) and
// refreshes the maxima up to the root, func 1 returns the maximum of elements
// 0 through position (position clamped to the count in use, -1 when empty),
// func 2 returns how many leading elements are strictly below operand_value,
// capped at the count in use. Unused fields of a result are zero, and code 3
// gives an all-zero result. All three operations walk the tree one level per
// cycle through the single memory read port and the shared compare unit. A
// result sits in an output register, so the next transfer is taken while it
// waits. After reset a clearing pass writes -1 to all 2048 memory words, during
// which in_stall stays high; configuration writes are taken at any time and
// elements_in_use is meant to change only while the block is idle.
module prefix_max_segment_tree_top
    import pmst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire cnt_t        elements_in_use,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire func_t       func,
    input  wire pos_t        position,
    input  wire val_t        operand_value,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output val_t             max_value,
    output cnt_t             leading_count
);

    cnt_t     elements_in_use_reg;
    cnt_t     count_in_use;
    ram_req_t ram_req;
    val_t     rd_data;
    val_t     cmp_a;
    val_t     cmp_b;
    cmp_res_t cmp;
    res_t     res;
    logic     res_take;

    logic     out_valid_reg, out_valid_next;
    val_t     max_value_reg;
    cnt_t     leading_count_reg;

    // the register is always ready for a transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elements_in_use_reg <= '0;
        end
        else if (cfg_valid)
        begin
            elements_in_use_reg <= elements_in_use;
        end
    end

    // counts above the leaf count mean a full tree
    assign count_in_use = (elements_in_use_reg > CNT_LEAF_FULL) ? CNT_LEAF_FULL
                                                                : elements_in_use_reg;

    pmst_node_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    pmst_cmp_unit u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    pmst_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .position      (position),
        .operand_value (operand_value),
        .count_in_use  (count_in_use),
        .ram_req       (ram_req),
        .rd_data       (rd_data),
        .cmp_a         (cmp_a),
        .cmp_b         (cmp_b),
        .cmp           (cmp),
        .res           (res),
        .res_take      (res_take)
    );

    // output register: loads when empty or when its transfer completes
    assign res_take = res.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            max_value_reg     <= res.max_value;
            leading_count_reg <= res.leading_count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign max_value     = max_value_reg;
    assign leading_count = leading_count_reg;

endmodule

`default_nettype wire

// File: rtl/core/pmst_checker.sv
// port-level checker of the prefix max segment tree and its bind
`default_nettype none

module pmst_checker
    import pmst_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  in_valid,
    input wire logic  in_stall,
    input wire logic  out_valid,
    input wire logic  out_stall,
    input wire val_t  max_value,
    input wire cnt_t  leading_count
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(max_value) && $stable(leading_count))
        else $error("result payload changed while stalled");

    // one item at a time: an accepted transfer makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer taken right after the first");

    // only one result field is live per operation
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (max_value == '0) || (leading_count == '0))
        else $error("both result fields nonzero");

    // the count never exceeds the leaf count
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> leading_count <= CNT_LEAF_FULL)
        else $error("leading count out of range");

endmodule

bind prefix_max_segment_tree_top pmst_checker u_pmst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .max_value     (max_value),
    .leading_count (leading_count)
);

`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench of the prefix max segment tree top level
`default_nettype none

module tb_top
    import pmst_pkg::*;
();

    // code 3 has no operation behind it and must give an all-zero result
    localparam func_t FUNC_UNUSED = 2'd3;

    // signed extremes of a 48-bit element
    localparam val_t VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};

    localparam int RANDOM_PHASES    = 12;
    localparam int ITEMS_PER_PHASE  = 62;
    // cycles left for the block to settle before a register write or the end
    localparam int SETTLE_CYCLES    = 24;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n;

    // configuration channel
    logic cfg_valid;
    logic cfg_ready;
    cnt_t elements_in_use;

    // input channel
    logic  in_valid;
    logic  in_stall;
    func_t func;
    pos_t  position;
    val_t  operand_value;

    // output channel
    logic out_valid;
    logic out_stall;
    val_t max_value;
    cnt_t leading_count;

    prefix_max_segment_tree_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .elements_in_use (elements_in_use),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .position        (position),
        .operand_value   (operand_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .max_value       (max_value),
        .leading_count   (leading_count)
    );

    always #2 clk = ~clk;

    // one result as the block should produce it
    typedef struct {
        val_t max_value;
        cnt_t leading_count;
    } tree_result_t;

    // one row of the directed table: a register write or an operation,
    // with a hand-typed result where it is obvious
    typedef struct {
        bit    is_cfg;
        cnt_t  count;
        func_t op;
        pos_t  pos;
        val_t  value;
        bit    typed;
        val_t  typed_max;
        cnt_t  typed_count;
    } stim_row_t;

    // predictor state: the leaf values and the register copy
    val_t leaf_value [LEAF_COUNT];
    cnt_t count_setting;

    tree_result_t pending_results[$];
    stim_row_t    stim_table[$];
    int           mismatch_count = 0;
    // when set, neither side inserts idle cycles
    bit           no_idle = 1'b0;

    // computes the result of one operation and applies its effect on the leaves
    task automatic tree_result(input func_t op, input pos_t pos, input val_t value,
                               output tree_result_t res);
        int n;
        int last;
        int i;
        n = (count_setting > CNT_LEAF_FULL) ? LEAF_COUNT : int'(count_setting);
        res.max_value     = '0;
        res.leading_count = '0;
        case (op)
            FUNC_WRITE:
            begin
                // values below -1 saturate at -1
                leaf_value[pos] = (value < VAL_NEG_ONE) ? VAL_NEG_ONE : value;
            end
            FUNC_PREFIX_MAX:
            begin
                res.max_value = VAL_NEG_ONE;
                if (n > 0)
                begin
                    // position past the count covers every element in use
                    last = (int'(pos) < n) ? int'(pos) : n - 1;
                    for (i = 0; i <= last; i++)
                        if (leaf_value[i] > res.max_value)
                            res.max_value = leaf_value[i];
                end
            end
            FUNC_COUNT_BELOW:
            begin
                i = 0;
                while (i < n && leaf_value[i] < value)
                    i++;
                res.leading_count = cnt_t'(i);
            end
            default:
            begin
            end
        endcase
    endtask

    // one input transfer after a random gap, predicted when it is taken
    task automatic send_op(input func_t op, input pos_t pos, input val_t value,
                           input bit typed, input val_t typed_max, input cnt_t typed_count);
        int           gap;
        tree_result_t res;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func          = op;
        position      = pos;
        operand_value = value;
        in_valid      = 1'b1;
        do @(posedge clk); while (in_stall);
        tree_result(op, pos, value, res);
        if (typed)
        begin
            res.max_value     = typed_max;
            res.leading_count = typed_count;
        end
        pending_results.insert(pending_results.size(), res);
    endtask

    // sender holds off until every expected result is back, then lets the block settle
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write through the configuration channel
    task automatic write_count(input cnt_t n);
        @(negedge clk);
        cfg_valid       = 1'b1;
        elements_in_use = n;
        do @(posedge clk); while (!cfg_ready);
        count_setting = n;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_cfg_row(input cnt_t n);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.count  = n;
        stim_table.insert(stim_table.size(), row);
    endtask

    task automatic add_op_row(input func_t op, input pos_t pos, input val_t value,
                              input bit typed, input val_t typed_max, input cnt_t typed_count);
        stim_row_t row;
        row = '{default: '0};
        row.op          = op;
        row.pos         = pos;
        row.value       = value;
        row.typed       = typed;
        row.typed_max   = typed_max;
        row.typed_count = typed_count;
        stim_table.insert(stim_table.size(), row);
    endtask

    // mostly small values so that searches walk deep, plus extremes and full noise
    function automatic val_t rand_value();
        int t;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                t = $urandom_range(0, 64);
                return val_t'(t - 2);
            end
            5:       return VAL_MAX;
            6:       return ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_NEG_ONE;
            default: return val_t'({$urandom, $urandom});
        endcase
    endfunction

    // output side: every accepted result transfer is checked against the oldest expectation
    always @(posedge clk)
    begin
        tree_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer max_value %0d leading_count %0d",
                         $time, max_value, leading_count);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (max_value !== want.max_value)
                begin
                    $display("%0t: max_value expected %0d actual %0d",
                             $time, want.max_value, max_value);
                    mismatch_count++;
                end
                if (leading_count !== want.leading_count)
                begin
                    $display("%0t: leading_count expected %0d actual %0d",
                             $time, want.leading_count, leading_count);
                    mismatch_count++;
                end
            end
        end
    end

    // output side stall: a random hold-off before each result transfer
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 7);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // hard limit on the run, well above the slowest correct run
    initial
    begin
        #2000000;
        $display("prefix_max_segment_tree_top verification failed");
        $finish;
    end

    // main sequence
    initial
    begin
        int        phase;
        int        k;
        int        n;
        int        sel;
        stim_row_t row;
        func_t     op;
        pos_t      pos;

        // all inputs known from time zero
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        elements_in_use = '0;
        in_valid        = 1'b0;
        func            = FUNC_WRITE;
        position        = '0;
        operand_value   = '0;
        count_setting   = '0;
        for (k = 0; k < LEAF_COUNT; k++)
            leaf_value[k] = VAL_NEG_ONE;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        // empty tree after reset
        add_op_row(FUNC_PREFIX_MAX, 10'd0, val_t'(0), 1, VAL_NEG_ONE, 0);
        add_op_row(FUNC_COUNT_BELOW, 10'd0, val_t'(5), 1, val_t'(0), 0);
        add_op_row(FUNC_UNUSED, 10'd1023, VAL_MAX, 1, val_t'(0), 0);
        // full tree, still all -1
        add_cfg_row(CNT_LEAF_FULL);
        add_op_row(FUNC_PREFIX_MAX, 10'd1023, val_t'(0), 1, VAL_NEG_ONE, 0);
        add_op_row(FUNC_COUNT_BELOW, 10'd0, VAL_NEG_ONE, 1, val_t'(0), 0);
        // every element below the threshold gives the count in use
        add_op_row(FUNC_COUNT_BELOW, 10'd0, val_t'(0), 1, val_t'(0), CNT_LEAF_FULL);
        add_op_row(FUNC_WRITE, 10'd0, VAL_MAX, 1, val_t'(0), 0);
        add_op_row(FUNC_PREFIX_MAX, 10'd0, val_t'(0), 1, VAL_MAX, 0);
        // values below -1 saturate
        add_op_row(FUNC_WRITE, 10'd1023, VAL_MIN, 1, val_t'(0), 0);
        add_op_row(FUNC_WRITE, 10'd5, val_t'(-2), 1, val_t'(0), 0);
        add_op_row(FUNC_WRITE, 10'd3, val_t'(48'h5555_5555_5555), 0, val_t'(0), 0);
        add_op_row(FUNC_WRITE, 10'd1, val_t'(48'h2AAA_AAAA_AAAA), 0, val_t'(0), 0);
        add_op_row(FUNC_PREFIX_MAX, 10'd2, val_t'(0), 1, VAL_MAX, 0);
        add_op_row(FUNC_COUNT_BELOW, 10'd0, VAL_MAX, 1, val_t'(0), 0);
        add_op_row(FUNC_PREFIX_MAX, 10'd1023, VAL_MIN, 0, val_t'(0), 0);
        add_op_row(FUNC_UNUSED, 10'd1023, VAL_NEG_ONE, 1, val_t'(0), 0);
        // short tree: query position clamped, write past the count hidden
        add_cfg_row(cnt_t'(2));
        add_op_row(FUNC_PREFIX_MAX, 10'd1023, val_t'(0), 1, VAL_MAX, 0);
        add_op_row(FUNC_WRITE, 10'd0, val_t'(0), 0, val_t'(0), 0);
        add_op_row(FUNC_PREFIX_MAX, 10'd1023, val_t'(0), 0, val_t'(0), 0);
        add_op_row(FUNC_WRITE, 10'd1, VAL_NEG_ONE, 0, val_t'(0), 0);
        add_op_row(FUNC_WRITE, 10'd700, val_t'(9), 0, val_t'(0), 0);
        add_op_row(FUNC_COUNT_BELOW, 10'd0, val_t'(1), 0, val_t'(0), 0);
        // count above the leaf count acts as the full tree
        add_cfg_row(cnt_t'(11'h7FF));
        add_op_row(FUNC_PREFIX_MAX, 10'd1023, val_t'(0), 0, val_t'(0), 0);
        add_op_row(FUNC_COUNT_BELOW, 10'd0, val_t'(10), 0, val_t'(0), 0);

        for (k = 0; k < stim_table.size(); k++)
        begin
            row = stim_table[k];
            if (row.is_cfg)
            begin
                drain_results();
                write_count(row.count);
            end
            else
            begin
                send_op(row.op, row.pos, row.value, row.typed, row.typed_max, row.typed_count);
            end
        end

        // random phases, each under its own register setting
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            no_idle = (phase % 4 == 3);
            case (phase)
                0:       write_count(CNT_LEAF_FULL);
                1:       write_count('0);
                2:       write_count(cnt_t'(11'h7FF));
                3:       write_count(cnt_t'(1));
                default:
                    if ($urandom_range(0, 1) != 0)
                        write_count(cnt_t'($urandom_range(0, 2047)));
                    else
                        write_count(cnt_t'($urandom_range(1, 40)));
            endcase
            n = (count_setting > CNT_LEAF_FULL) ? LEAF_COUNT : int'(count_setting);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    op = FUNC_WRITE;
                else if (sel < 65)
                    op = FUNC_PREFIX_MAX;
                else if (sel < 92)
                    op = FUNC_COUNT_BELOW;
                else
                    op = FUNC_UNUSED;
                // positions mostly inside the count in use
                if (n > 0 && $urandom_range(0, 3) != 0)
                    pos = pos_t'($urandom_range(0, n - 1));
                else
                    pos = pos_t'($urandom_range(0, LEAF_COUNT - 1));
                send_op(op, pos, rand_value(), 0, val_t'(0), 0);
                // now and then the sender waits for the output side to catch up
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("prefix_max_segment_tree_top verification clean");
        else
            $display("prefix_max_segment_tree_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
